/* hdl/assert_macros.svh */
// Assertion macros for the checker file.
// Each use sits on a line of its own; the enclosing scope supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ULED_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ULED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/uled_pkg.sv */
package uled_pkg;

  // Character codes
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_TILDE    = 8'h7E;

  // Input item kinds
  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Escape sequence phases; the unused code behaves as normal input
  localparam logic [1:0] ESC_NORMAL = 2'd0;
  localparam logic [1:0] ESC_SEEN   = 2'd1;
  localparam logic [1:0] ESC_CSI    = 2'd2;

  // Capacity after reset
  localparam logic [6:0] CAP_RESET = 7'd64;

  // One result transaction; mem_sel takes data from the store read register
  typedef struct packed {
    logic       is_echo;
    logic [7:0] data;
    logic       last;
    logic       line_done;
    logic       mem_sel;
  } res_t;

  // All results caused by one input item
  typedef struct packed {
    logic [1:0]       n;
    res_t [2:0]       res;
    logic [5:0]       line_length;
  } res_set_t;

endpackage

/* hdl/uart_line_editor_unit.sv */
// Line editor for bytes received from a UART.
// in_ channel: tuser 0 = received byte (tdata[7:0]), tuser 1 = read of the
//   stored character at tdata[13:8]. out_ channel: tuser 1 = echo byte to
//   transmit, 0 = read answer; tlast marks the final result of an item.
// cfg_we/cfg_wdata write the capacity; write it only while the block is idle.
// The first result of an item is valid the cycle after acceptance.
// Throughput: while out_tready is high, results leave one per cycle from a
//   three-slot result register; a new item is taken in the cycle its
//   predecessor's last result leaves, so printable bytes, reads and swallowed
//   bytes, which produce no result, run at one per cycle.
// Reset: line length, escape state and line-end flag clear, capacity returns
//   to 64; the line store itself is not cleared (it is only read below the
//   current length). Reset takes effect on the next clock edge.
// When the receiver stalls, the current result holds and in_tready falls
//   until the pending results are taken.
module uart_line_editor_unit #(
  parameter int LINE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte[7:0], read_index[13:8], zero[15:14]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data[7:0], line_done[8], line_length[14:9], zero[15]
  output logic        out_tuser,  // is_echo
  output logic        out_tlast
);

  logic               accept;
  uled_pkg::res_set_t set;
  logic [7:0]         rd_data;
  logic [7:0]         res_data;
  logic               res_done;
  logic [5:0]         res_len;

  assign accept = in_tvalid & in_tready;

  uled_ctrl #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .kind      (in_tuser),
    .rx_byte   (in_tdata[7:0]),
    .read_index(in_tdata[13:8]),
    .set       (set),
    .rd_data   (rd_data)
  );

  uled_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .set        (set),
    .rd_data    (rd_data),
    .out_ready  (out_tready),
    .can_load   (in_tready),
    .out_valid  (out_tvalid),
    .is_echo    (out_tuser),
    .data       (res_data),
    .last       (out_tlast),
    .line_done  (res_done),
    .line_length(res_len)
  );

  assign out_tdata = {1'b0, res_len, res_done, res_data};

endmodule

/* hdl/uled_ctrl.sv */
module uled_ctrl #(
  parameter int LINE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  input  logic              accept,
  input  logic              kind,
  input  logic [7:0]        rx_byte,
  input  logic [5:0]        read_index,
  output uled_pkg::res_set_t set,
  output logic [7:0]        rd_data
);

  localparam int CW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LW = (CW + 1 > 7) ? CW + 1 : 7;
  localparam int IW = ((CW > 6) ? CW : 6) + 1;

  logic [CW-1:0] count_r, count_nxt, base;
  logic [1:0]    esc_r, esc_nxt;
  logic          ended_r, ended_nxt;
  logic [6:0]    cap_r;
  logic          wr_en;
  logic [LW-1:0] limit;
  logic [IW-1:0] idx_x, len_x;
  logic          hit;
  logic [7:0]    mem [LINE_DEPTH];
  logic [7:0]    rd_data_r;

  assign limit = (LW'(cap_r) < LW'(LINE_DEPTH)) ? LW'(cap_r) : LW'(LINE_DEPTH);
  assign idx_x = IW'(read_index);
  assign hit   = (idx_x < IW'(count_r)) && (idx_x < IW'(LINE_DEPTH));
  assign len_x = IW'(count_nxt);

  // Decode the item against the current line state
  always_comb begin
    count_nxt = count_r;
    esc_nxt   = esc_r;
    ended_nxt = ended_r;
    wr_en     = 1'b0;
    base      = count_r;
    set       = '0;
    if (kind == uled_pkg::KIND_READ) begin
      set.n              = 2'd1;
      set.res[0].last    = 1'b1;
      set.res[0].mem_sel = hit;
    end else begin
      // first byte after a finished line starts a new one
      if (ended_r) begin
        base = '0;
      end
      ended_nxt = 1'b0;
      count_nxt = base;
      case (esc_r)
        uled_pkg::ESC_SEEN: begin
          esc_nxt = (rx_byte == uled_pkg::CH_LBRACKET) ? uled_pkg::ESC_CSI
                                                       : uled_pkg::ESC_NORMAL;
        end
        uled_pkg::ESC_CSI: begin
          if (rx_byte == uled_pkg::CH_TILDE) begin
            esc_nxt = uled_pkg::ESC_NORMAL;
          end
        end
        default: begin
          esc_nxt = uled_pkg::ESC_NORMAL;
          if (rx_byte == uled_pkg::CH_CR) begin
            ended_nxt = 1'b1;
            set.n     = 2'd2;
            set.res[0] = '{is_echo: 1'b1, data: uled_pkg::CH_CR, last: 1'b0,
                           line_done: 1'b1, mem_sel: 1'b0};
            set.res[1] = '{is_echo: 1'b1, data: uled_pkg::CH_LF, last: 1'b1,
                           line_done: 1'b1, mem_sel: 1'b0};
          end else if (limit != '0) begin
            if (rx_byte inside {[uled_pkg::CH_SPACE:uled_pkg::CH_TILDE]}) begin
              if ((LW'(base) + LW'(1)) < limit) begin
                wr_en      = 1'b1;
                count_nxt  = base + CW'(1);
                set.n      = 2'd1;
                set.res[0] = '{is_echo: 1'b1, data: rx_byte, last: 1'b1,
                               line_done: 1'b0, mem_sel: 1'b0};
              end
            end else if (rx_byte == uled_pkg::CH_BS) begin
              if (base != '0) begin
                count_nxt  = base - CW'(1);
                set.n      = 2'd3;
                set.res[0] = '{is_echo: 1'b1, data: uled_pkg::CH_BS, last: 1'b0,
                               line_done: 1'b0, mem_sel: 1'b0};
                set.res[1] = '{is_echo: 1'b1, data: uled_pkg::CH_SPACE, last: 1'b0,
                               line_done: 1'b0, mem_sel: 1'b0};
                set.res[2] = '{is_echo: 1'b1, data: uled_pkg::CH_BS, last: 1'b1,
                               line_done: 1'b0, mem_sel: 1'b0};
              end
            end else if (rx_byte == uled_pkg::CH_ESC) begin
              esc_nxt = uled_pkg::ESC_SEEN;
            end
          end
        end
      endcase
    end
    set.line_length = len_x[5:0];
  end

  // Hold line state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      esc_r   <= uled_pkg::ESC_NORMAL;
      ended_r <= 1'b0;
      cap_r   <= uled_pkg::CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        count_r <= count_nxt;
        esc_r   <= esc_nxt;
        ended_r <= ended_nxt;
      end
    end
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[base] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[idx_x[CW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/uled_out.sv */
module uled_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  uled_pkg::res_set_t set,
  input  logic [7:0]         rd_data,
  input  logic               out_ready,
  output logic               can_load,
  output logic               out_valid,
  output logic               is_echo,
  output logic [7:0]         data,
  output logic               last,
  output logic               line_done,
  output logic [5:0]         line_length
);

  logic [1:0]             cnt_r;
  uled_pkg::res_t [2:0]   slot_r;
  logic [5:0]             len_r;
  logic                   fire;

  assign out_valid = (cnt_r != 2'd0);
  assign fire      = out_valid & out_ready;
  // take a new item once the last pending result leaves
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  // Count pending results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= set.n;
    end else if (fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Load a result set or shift out the front slot
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= set.res;
      len_r  <= set.line_length;
    end else if (fire) begin
      slot_r <= {uled_pkg::res_t'('0), slot_r[2], slot_r[1]};
    end
  end

  assign is_echo     = slot_r[0].is_echo;
  assign data        = slot_r[0].mem_sel ? rd_data : slot_r[0].data;
  assign last        = slot_r[0].last;
  assign line_done   = slot_r[0].line_done;
  assign line_length = len_r;

endmodule

/* hdl/uled_checker.sv */
`include "assert_macros.svh"

module uled_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // Stalled result holds
  `ULED_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // Line end echoes CR first
  `ULED_ASSERT(a_done_cr, out_tvalid && out_tdata[8] && !out_tlast, out_tuser && (out_tdata[7:0] == uled_pkg::CH_CR), "line end first result is not CR")

  // Line end echoes LF last
  `ULED_ASSERT(a_done_lf, out_tvalid && out_tdata[8] && out_tlast, out_tuser && (out_tdata[7:0] == uled_pkg::CH_LF), "line end last result is not LF")

  // Read answers are single results, never a line end
  `ULED_ASSERT(a_read_single, out_tvalid && !out_tuser, out_tlast && !out_tdata[8], "read answer not a lone result")

endmodule

bind uart_line_editor_unit uled_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
